@@ rtl/core/iim_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Interval table package
// Shared sizes, codes and the structs that pass between the sequencer and
// the scan unit of the interval insert-and-merge table.
// ----------------------------------------------------------------------------
package iim_pkg;

   localparam int CAPACITY    = 32;
   localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int VAL_W       = 32;
   localparam int ENTRY_W     = 2 * VAL_W;
   localparam int COUNT_OUT_W = 6;

   typedef logic [CNT_W-1:0]        count_type;
   typedef logic signed [VAL_W-1:0] value_type;

   localparam logic FUNC_INSERT = 1'b0;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_BAD  = 2'd2;

   // Control of the scan unit: clear its accumulators, or take one entry.
   typedef struct packed {
      logic clear;
      logic enable;
   } scan_ctl_type;

   // What the scan has found over the entries it was given.
   typedef struct packed {
      count_type below;     // entries that end before the new start
      count_type reach;     // entries that start no later than the new end
      logic      hit;       // at least one entry overlaps or touches
      value_type first_lo;  // start of the first overlapping entry
      value_type last_hi;   // end of the last overlapping entry
   } scan_res_type;

endpackage
`default_nettype wire

@@ rtl/core/iim_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iim_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/iim_scan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Interval scan unit
// Compares one stored entry per cycle, while enabled, against the new interval
// and keeps the counts and bounds needed to plan the merge or insertion.
// ----------------------------------------------------------------------------
module iim_scan
   import iim_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire scan_ctl_type ctl,
   input  wire value_type    entry_lo,
   input  wire value_type    entry_hi,
   input  wire value_type    key_start,
   input  wire value_type    key_end,
   output scan_res_type      res
);

   count_type below_ff, below_in;
   count_type reach_ff, reach_in;
   logic      hit_ff, hit_in;
   value_type first_lo_ff, first_lo_in;
   value_type last_hi_ff, last_hi_in;
   logic      ends_before;
   logic      starts_within;

   // The table is sorted and disjoint, so both conditions hold on a prefix.
   assign ends_before   = $signed(entry_hi) < $signed(key_start);
   assign starts_within = $signed(entry_lo) <= $signed(key_end);

   always_comb begin
      below_in    = below_ff;
      reach_in    = reach_ff;
      hit_in      = hit_ff;
      first_lo_in = first_lo_ff;
      last_hi_in  = last_hi_ff;
      if (ctl.clear) begin
         below_in = '0;
         reach_in = '0;
         hit_in   = 1'b0;
      end else if (ctl.enable) begin
         below_in = below_ff + count_type'(ends_before);
         reach_in = reach_ff + count_type'(starts_within);
         if (!ends_before && starts_within) begin
            if (!hit_ff) begin
               first_lo_in = entry_lo;
            end
            last_hi_in = entry_hi;
            hit_in     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         below_ff <= '0;
         reach_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         below_ff <= below_in;
         reach_ff <= reach_in;
         hit_ff   <= hit_in;
      end
      first_lo_ff <= first_lo_in;
      last_hi_ff  <= last_hi_in;
   end

   assign res.below    = below_ff;
   assign res.reach    = reach_ff;
   assign res.hit      = hit_ff;
   assign res.first_lo = first_lo_ff;
   assign res.last_hi  = last_hi_ff;

endmodule
`default_nettype wire

@@ rtl/core/interval_insert_merge_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Interval insert-and-merge table
// Keeps a sorted table of disjoint closed intervals, merges or inserts a new
// interval or clears the table, and emits the whole table after every command.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                   Transfer when
//   -------   -------------------------------------   -----------------------
//   command   start, busy, req_func, req_new_start,    start high, busy low
//             req_new_end
//   result    rsp_strobe, rsp_entry_start/end/valid,   rsp_strobe high
//             rsp_is_last, rsp_status, rsp_table_count
//
// An insert keeps busy high through a scan pass over the n entries of the
// table in the compare unit, a planning state, and a second pass that reads
// and emits the n' entries of the new table, one per cycle, set by the one
// read address that both table banks share, and writes them to the other
// bank when the table changes.
// An inverted insert skips the scan and the planning and goes straight to the
// second pass; a clear, or an inverted insert on an empty table, emits only a
// single result that marks the table as empty.
// Reset empties the table at once; there is no clearing pass.
// The receiver cannot stall: each result transfer lasts exactly one cycle.
// ----------------------------------------------------------------------------
module interval_insert_merge_table
   import iim_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_func,
   input  wire value_type  req_new_start,
   input  wire value_type  req_new_end,
   output logic            rsp_strobe,
   output value_type       rsp_entry_start,
   output value_type       rsp_entry_end,
   output logic            rsp_entry_valid,
   output logic            rsp_is_last,
   output logic [1:0]      rsp_status,
   output logic [COUNT_OUT_W-1:0] rsp_table_count
);

   // One-hot sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_PLAN  = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_EMPTY = 5'b10000
   } state_type;

   // How the second pass builds the new table from the old one.
   typedef enum logic [1:0] {
      MODE_KEEP   = 2'd0,
      MODE_MERGE  = 2'd1,
      MODE_INSERT = 2'd2
   } mode_type;

   state_type  state_ff, state_in;
   mode_type   mode_ff, mode_in;
   count_type  count_ff, count_in;
   logic       bank_ff, bank_in;
   value_type  key_start_ff, key_start_in;
   value_type  key_end_ff, key_end_in;
   logic [1:0] status_ff, status_in;
   count_type  new_cnt_ff, new_cnt_in;
   count_type  first_ff, first_in;
   count_type  gone_ff, gone_in;
   value_type  mlo_ff, mlo_in;
   value_type  mhi_ff, mhi_in;
   count_type  idx_ff, idx_in;
   logic       rd_vld_ff, rd_vld_in;
   count_type  rd_idx_ff, rd_idx_in;
   logic       rd_merged_ff, rd_merged_in;
   logic       rd_last_ff, rd_last_in;

   logic       rsp_strobe_ff, rsp_strobe_in;
   value_type  rsp_start_ff, rsp_start_in;
   value_type  rsp_end_ff, rsp_end_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_last_ff, rsp_last_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   scan_ctl_type       scan_ctl;
   scan_res_type       scan_res;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data0;
   logic [ENTRY_W-1:0] rd_data1;
   logic [ENTRY_W-1:0] rd_data;
   logic [ENTRY_W-1:0] wr_data;
   logic               wr_en;
   count_type          src;
   value_type          rd_lo;
   value_type          rd_hi;

   // Two banks: the second pass reads the current one and writes the other,
   // so that shifting up or down never overwrites an entry still to be read.
   assign rd_data = bank_ff ? rd_data1 : rd_data0;
   assign rd_lo   = value_type'(rd_data[ENTRY_W-1:VAL_W]);
   assign rd_hi   = value_type'(rd_data[VAL_W-1:0]);
   assign wr_en   = (state_ff == ST_EMIT) && rd_vld_ff && (mode_ff != MODE_KEEP);
   assign wr_data = rd_merged_ff ? {mlo_ff, mhi_ff} : rd_data;

   iim_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en && bank_ff),
      .wr_addr (rd_idx_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   iim_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en && !bank_ff),
      .wr_addr (rd_idx_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

   iim_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .entry_lo  (rd_lo),
      .entry_hi  (rd_hi),
      .key_start (key_start_ff),
      .key_end   (key_end_ff),
      .res       (scan_res)
   );

   // Source entry of the old table for output position idx_ff. Merging drops
   // the overlapped run after the first position; inserting opens a gap.
   always_comb begin
      case (mode_ff)
         MODE_MERGE: begin
            src = (idx_ff > first_ff) ? idx_ff + gone_ff : idx_ff;
         end
         MODE_INSERT: begin
            src = (idx_ff > first_ff) ? idx_ff - count_type'(1) : idx_ff;
         end
         default: begin
            src = idx_ff;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      bank_in       = bank_ff;
      key_start_in  = key_start_ff;
      key_end_in    = key_end_ff;
      status_in     = status_ff;
      new_cnt_in    = new_cnt_ff;
      first_in      = first_ff;
      gone_in       = gone_ff;
      mlo_in        = mlo_ff;
      mhi_in        = mhi_ff;
      idx_in        = idx_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      rd_merged_in  = rd_merged_ff;
      rd_last_in    = rd_last_ff;
      rd_addr       = idx_ff[ADDR_W-1:0];
      scan_ctl      = '0;
      rsp_strobe_in = 1'b0;
      rsp_start_in  = rsp_start_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_start_in = req_new_start;
               key_end_in   = req_new_end;
               idx_in       = '0;
               if (req_func == FUNC_INSERT) begin
                  if ($signed(req_new_start) > $signed(req_new_end)) begin
                     // Reversed interval: the table is emitted unchanged.
                     status_in  = STATUS_BAD;
                     mode_in    = MODE_KEEP;
                     new_cnt_in = count_ff;
                     state_in   = (count_ff == '0) ? ST_EMPTY : ST_EMIT;
                  end else begin
                     status_in      = STATUS_OK;
                     scan_ctl.clear = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end else begin
                  status_in  = STATUS_OK;
                  count_in   = '0;
                  new_cnt_in = '0;
                  state_in   = ST_EMPTY;
               end
            end
         end

         ST_SCAN: begin
            // Read data arrives in the cycle after its address.
            scan_ctl.enable = rd_vld_ff;
            if (idx_ff < count_ff) begin
               rd_vld_in = 1'b1;
               idx_in    = idx_ff + count_type'(1);
            end else if (!rd_vld_ff) begin
               state_in = ST_PLAN;
            end
         end

         ST_PLAN: begin
            idx_in   = '0;
            first_in = scan_res.below;
            state_in = ST_EMIT;
            if (scan_res.hit) begin
               mode_in    = MODE_MERGE;
               gone_in    = scan_res.reach - scan_res.below - count_type'(1);
               new_cnt_in = count_ff - (scan_res.reach - scan_res.below - count_type'(1));
               mlo_in     = ($signed(scan_res.first_lo) < $signed(key_start_ff)) ?
                            scan_res.first_lo : key_start_ff;
               mhi_in     = ($signed(scan_res.last_hi) > $signed(key_end_ff)) ?
                            scan_res.last_hi : key_end_ff;
            end else if (count_ff == count_type'(CAPACITY)) begin
               mode_in    = MODE_KEEP;
               status_in  = STATUS_FULL;
               new_cnt_in = count_ff;
            end else begin
               mode_in    = MODE_INSERT;
               new_cnt_in = count_ff + count_type'(1);
               mlo_in     = key_start_ff;
               mhi_in     = key_end_ff;
            end
         end

         ST_EMIT: begin
            if (idx_ff < new_cnt_ff) begin
               rd_addr      = src[ADDR_W-1:0];
               rd_vld_in    = 1'b1;
               rd_idx_in    = idx_ff;
               rd_merged_in = (mode_ff != MODE_KEEP) && (idx_ff == first_ff);
               rd_last_in   = (idx_ff + count_type'(1)) == new_cnt_ff;
               idx_in       = idx_ff + count_type'(1);
            end else if (!rd_vld_ff) begin
               if (mode_ff != MODE_KEEP) begin
                  bank_in  = !bank_ff;
                  count_in = new_cnt_ff;
               end
               state_in = ST_IDLE;
            end
            if (rd_vld_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_start_in  = rd_merged_ff ? mlo_ff : rd_lo;
               rsp_end_in    = rd_merged_ff ? mhi_ff : rd_hi;
               rsp_valid_in  = 1'b1;
               rsp_last_in   = rd_last_ff;
               rsp_status_in = status_ff;
               rsp_count_in  = COUNT_OUT_W'(new_cnt_ff);
            end
         end

         ST_EMPTY: begin
            rsp_strobe_in = 1'b1;
            rsp_start_in  = '0;
            rsp_end_in    = '0;
            rsp_valid_in  = 1'b0;
            rsp_last_in   = 1'b1;
            rsp_status_in = status_ff;
            rsp_count_in  = COUNT_OUT_W'(count_ff);
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_KEEP;
         count_ff      <= '0;
         bank_ff       <= 1'b0;
         idx_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         bank_ff       <= bank_in;
         idx_ff        <= idx_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      key_start_ff  <= key_start_in;
      key_end_ff    <= key_end_in;
      status_ff     <= status_in;
      new_cnt_ff    <= new_cnt_in;
      first_ff      <= first_in;
      gone_ff       <= gone_in;
      mlo_ff        <= mlo_in;
      mhi_ff        <= mhi_in;
      rd_idx_ff     <= rd_idx_in;
      rd_merged_ff  <= rd_merged_in;
      rd_last_ff    <= rd_last_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_entry_start = rsp_start_ff;
   assign rsp_entry_end   = rsp_end_ff;
   assign rsp_entry_valid = rsp_valid_ff;
   assign rsp_is_last     = rsp_last_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_table_count = rsp_count_ff;

endmodule
`default_nettype wire
